// ===== rtl/core/segment_pair_conflict_check_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the segment pair conflict checker
// Clocked property wrappers; all expect clk in scope, SPCC_ASSERT also rst_n.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_PAIR_CONFLICT_CHECK_ASSERT_SVH
`define SEGMENT_PAIR_CONFLICT_CHECK_ASSERT_SVH

// checked only while out of reset
`define SPCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SPCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/spcc_pkg.sv =====
// ---------------------------------------------------------------------------
// spcc_pkg
// Shared constants, operand indexes and stage flag types.
// ---------------------------------------------------------------------------
package spcc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int OUT_TDATA_W    = 8;

  // point differences
  localparam int NDIFF = 12;
  localparam int D_RX  = 0;   // x2 - x1
  localparam int D_RY  = 1;   // y2 - y1
  localparam int D_SX  = 2;   // x4 - x3
  localparam int D_SY  = 3;   // y4 - y3
  localparam int D_QX  = 4;   // x3 - x1
  localparam int D_QY  = 5;   // y3 - y1
  localparam int D_AX  = 6;   // x4 - x1
  localparam int D_AY  = 7;   // y4 - y1
  localparam int D_BX  = 8;   // x1 - x3
  localparam int D_BY  = 9;   // y1 - y3
  localparam int D_CX  = 10;  // x2 - x3
  localparam int D_CY  = 11;  // y2 - y3

  // partial products; each cross product is A - B
  localparam int NPROD  = 12;
  localparam int M_DEN_A = 0;   // rx*sy
  localparam int M_DEN_B = 1;   // ry*sx
  localparam int M_C1_A  = 2;   // rx*qy
  localparam int M_C1_B  = 3;   // ry*qx
  localparam int M_C2_A  = 4;   // rx*ay
  localparam int M_C2_B  = 5;   // ry*ax
  localparam int M_C3_A  = 6;   // sx*by
  localparam int M_C3_B  = 7;   // sy*bx
  localparam int M_C4_A  = 8;   // sx*cy
  localparam int M_C4_B  = 9;   // sy*cx
  localparam int M_TN_A  = 10;  // qx*sy
  localparam int M_TN_B  = 11;  // qy*sx

  typedef struct packed {
    logic adjacent;   // P2 == P3
    logic apart;      // x or y extents disjoint
  } spcc_flags_t;

  typedef struct packed {
    logic adjacent;
    logic apart;
    logic collinear;  // all four point crosses zero
  } spcc_stat_t;

endpackage

// ===== rtl/core/spcc_diff.sv =====
// ---------------------------------------------------------------------------
// spcc_diff
// Stage 1: coordinate differences, adjacency and extent-overlap flags.
// ---------------------------------------------------------------------------
module spcc_diff #(
  parameter  int COORD_BITS = spcc_pkg::COORD_BITS_DEF,
  localparam int DW         = COORD_BITS + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [8*COORD_BITS-1:0]       data_i,
  output logic                          valid_o,
  output logic signed [DW-1:0]          diff_o [spcc_pkg::NDIFF],
  output spcc_pkg::spcc_flags_t         flags_o
);

  logic signed [COORD_BITS-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  logic signed [DW-1:0]         diff_nxt [spcc_pkg::NDIFF];
  spcc_pkg::spcc_flags_t        flags_nxt;
  logic                         apart_x, apart_y;

  assign x1 = $signed(data_i[0*COORD_BITS +: COORD_BITS]);
  assign y1 = $signed(data_i[1*COORD_BITS +: COORD_BITS]);
  assign x2 = $signed(data_i[2*COORD_BITS +: COORD_BITS]);
  assign y2 = $signed(data_i[3*COORD_BITS +: COORD_BITS]);
  assign x3 = $signed(data_i[4*COORD_BITS +: COORD_BITS]);
  assign y3 = $signed(data_i[5*COORD_BITS +: COORD_BITS]);
  assign x4 = $signed(data_i[6*COORD_BITS +: COORD_BITS]);
  assign y4 = $signed(data_i[7*COORD_BITS +: COORD_BITS]);

  always_comb begin
    diff_nxt[spcc_pkg::D_RX] = DW'(x2) - DW'(x1);
    diff_nxt[spcc_pkg::D_RY] = DW'(y2) - DW'(y1);
    diff_nxt[spcc_pkg::D_SX] = DW'(x4) - DW'(x3);
    diff_nxt[spcc_pkg::D_SY] = DW'(y4) - DW'(y3);
    diff_nxt[spcc_pkg::D_QX] = DW'(x3) - DW'(x1);
    diff_nxt[spcc_pkg::D_QY] = DW'(y3) - DW'(y1);
    diff_nxt[spcc_pkg::D_AX] = DW'(x4) - DW'(x1);
    diff_nxt[spcc_pkg::D_AY] = DW'(y4) - DW'(y1);
    diff_nxt[spcc_pkg::D_BX] = DW'(x1) - DW'(x3);
    diff_nxt[spcc_pkg::D_BY] = DW'(y1) - DW'(y3);
    diff_nxt[spcc_pkg::D_CX] = DW'(x2) - DW'(x3);
    diff_nxt[spcc_pkg::D_CY] = DW'(y2) - DW'(y3);
  end

  // disjoint extents: both ends of one segment lie below both ends of the other
  assign apart_x = (x1 < x3 && x1 < x4 && x2 < x3 && x2 < x4) ||
                   (x3 < x1 && x3 < x2 && x4 < x1 && x4 < x2);
  assign apart_y = (y1 < y3 && y1 < y4 && y2 < y3 && y2 < y4) ||
                   (y3 < y1 && y3 < y2 && y4 < y1 && y4 < y2);

  always_comb begin
    flags_nxt.adjacent = (x2 == x3) && (y2 == y3);
    flags_nxt.apart    = apart_x || apart_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      diff_o  <= diff_nxt;
      flags_o <= flags_nxt;
    end
  end

endmodule

// ===== rtl/core/spcc_mul.sv =====
// ---------------------------------------------------------------------------
// spcc_mul
// Stage 2: the twelve partial products of the cross products.
// ---------------------------------------------------------------------------
module spcc_mul #(
  parameter  int COORD_BITS = spcc_pkg::COORD_BITS_DEF,
  localparam int DW         = COORD_BITS + 1,
  localparam int PW         = 2 * DW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [DW-1:0]          diff_i [spcc_pkg::NDIFF],
  input  spcc_pkg::spcc_flags_t         flags_i,
  output logic                          valid_o,
  output logic signed [PW-1:0]          prod_o [spcc_pkg::NPROD],
  output spcc_pkg::spcc_flags_t         flags_o
);

  logic signed [PW-1:0] prod_nxt [spcc_pkg::NPROD];

  function automatic logic signed [PW-1:0] smul(logic signed [DW-1:0] a,
                                                logic signed [DW-1:0] b);
    return PW'(a) * PW'(b);
  endfunction

  always_comb begin
    prod_nxt[spcc_pkg::M_DEN_A] = smul(diff_i[spcc_pkg::D_RX], diff_i[spcc_pkg::D_SY]);
    prod_nxt[spcc_pkg::M_DEN_B] = smul(diff_i[spcc_pkg::D_RY], diff_i[spcc_pkg::D_SX]);
    prod_nxt[spcc_pkg::M_C1_A]  = smul(diff_i[spcc_pkg::D_RX], diff_i[spcc_pkg::D_QY]);
    prod_nxt[spcc_pkg::M_C1_B]  = smul(diff_i[spcc_pkg::D_RY], diff_i[spcc_pkg::D_QX]);
    prod_nxt[spcc_pkg::M_C2_A]  = smul(diff_i[spcc_pkg::D_RX], diff_i[spcc_pkg::D_AY]);
    prod_nxt[spcc_pkg::M_C2_B]  = smul(diff_i[spcc_pkg::D_RY], diff_i[spcc_pkg::D_AX]);
    prod_nxt[spcc_pkg::M_C3_A]  = smul(diff_i[spcc_pkg::D_SX], diff_i[spcc_pkg::D_BY]);
    prod_nxt[spcc_pkg::M_C3_B]  = smul(diff_i[spcc_pkg::D_SY], diff_i[spcc_pkg::D_BX]);
    prod_nxt[spcc_pkg::M_C4_A]  = smul(diff_i[spcc_pkg::D_SX], diff_i[spcc_pkg::D_CY]);
    prod_nxt[spcc_pkg::M_C4_B]  = smul(diff_i[spcc_pkg::D_SY], diff_i[spcc_pkg::D_CX]);
    prod_nxt[spcc_pkg::M_TN_A]  = smul(diff_i[spcc_pkg::D_QX], diff_i[spcc_pkg::D_SY]);
    prod_nxt[spcc_pkg::M_TN_B]  = smul(diff_i[spcc_pkg::D_QY], diff_i[spcc_pkg::D_SX]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      prod_o  <= prod_nxt;
      flags_o <= flags_i;
    end
  end

endmodule

// ===== rtl/core/spcc_cross.sv =====
// ---------------------------------------------------------------------------
// spcc_cross
// Stage 3: determinant and crossing numerators, collinearity test.
// ---------------------------------------------------------------------------
module spcc_cross #(
  parameter  int COORD_BITS = spcc_pkg::COORD_BITS_DEF,
  localparam int PW         = 2 * (COORD_BITS + 1),
  localparam int CW         = PW + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [PW-1:0]          prod_i [spcc_pkg::NPROD],
  input  spcc_pkg::spcc_flags_t         flags_i,
  output logic                          valid_o,
  output logic signed [CW-1:0]          den_o,
  output logic signed [CW-1:0]          tn_o,
  output logic signed [CW-1:0]          un_o,
  output spcc_pkg::spcc_stat_t          stat_o
);

  logic signed [CW-1:0]  den_nxt, tn_nxt, un_nxt;
  spcc_pkg::spcc_stat_t  stat_nxt;

  assign den_nxt = CW'(prod_i[spcc_pkg::M_DEN_A]) - CW'(prod_i[spcc_pkg::M_DEN_B]);
  assign tn_nxt  = CW'(prod_i[spcc_pkg::M_TN_A])  - CW'(prod_i[spcc_pkg::M_TN_B]);
  // un = cross(q, r) is the negated first collinearity cross
  assign un_nxt  = CW'(prod_i[spcc_pkg::M_C1_B])  - CW'(prod_i[spcc_pkg::M_C1_A]);

  always_comb begin
    stat_nxt.adjacent  = flags_i.adjacent;
    stat_nxt.apart     = flags_i.apart;
    stat_nxt.collinear = (prod_i[spcc_pkg::M_C1_A] == prod_i[spcc_pkg::M_C1_B]) &&
                         (prod_i[spcc_pkg::M_C2_A] == prod_i[spcc_pkg::M_C2_B]) &&
                         (prod_i[spcc_pkg::M_C3_A] == prod_i[spcc_pkg::M_C3_B]) &&
                         (prod_i[spcc_pkg::M_C4_A] == prod_i[spcc_pkg::M_C4_B]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      den_o  <= den_nxt;
      tn_o   <= tn_nxt;
      un_o   <= un_nxt;
      stat_o <= stat_nxt;
    end
  end

endmodule

// ===== rtl/core/spcc_decide.sv =====
// ---------------------------------------------------------------------------
// spcc_decide
// Stage 4: case selection and range compares; holds the output beat.
// ---------------------------------------------------------------------------
module spcc_decide #(
  parameter  int COORD_BITS = spcc_pkg::COORD_BITS_DEF,
  localparam int CW         = 2 * (COORD_BITS + 1) + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [CW-1:0]          den_i,
  input  logic signed [CW-1:0]          tn_i,
  input  logic signed [CW-1:0]          un_i,
  input  spcc_pkg::spcc_stat_t          stat_i,
  output logic                          valid_o,
  output logic                          clear_o
);

  logic clear_nxt;
  logic den_zero, den_neg;
  logic inside_pos, inside_neg;

  assign den_zero = (den_i == '0);
  assign den_neg  = den_i[CW-1];

  // crossing point on both segments; for a negative determinant the
  // range flips instead of negating all three terms
  assign inside_pos = (tn_i >= 0) && (tn_i <= den_i) && (un_i >= 0) && (un_i <= den_i);
  assign inside_neg = (tn_i <= 0) && (tn_i >= den_i) && (un_i <= 0) && (un_i >= den_i);

  always_comb begin
    priority if (den_zero) begin
      clear_nxt = stat_i.collinear ? stat_i.apart : 1'b1;
    end else if (stat_i.adjacent) begin
      clear_nxt = 1'b1;
    end else begin
      clear_nxt = den_neg ? !inside_neg : !inside_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      clear_o <= clear_nxt;
    end
  end

endmodule

// ===== rtl/core/segment_pair_conflict_check.sv =====
// ---------------------------------------------------------------------------
// segment_pair_conflict_check: exact segment crossing/overlap test, 4 stages
// Each input beat passes the diff, mul, cross and decide stage registers in order.
// Throughput: 1 pair per cycle; per-stage ready chain, full pipe holds on stall.
// Reset: synchronous active-low rst_n clears all stage valids; no output beat.
// ---------------------------------------------------------------------------
module segment_pair_conflict_check #(
  parameter  int COORD_BITS = spcc_pkg::COORD_BITS_DEF,
  localparam int IN_W       = ((8 * COORD_BITS + 7) / 8) * 8,
  localparam int DW         = COORD_BITS + 1,
  localparam int PW         = 2 * DW,
  localparam int CW         = PW + 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  logic [IN_W-1:0]                 in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // segments_clear
  output logic [spcc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic en1, en2, en3, en4;
  logic v1, v2, v3, v4;
  logic clear;

  logic signed [DW-1:0]  diff   [spcc_pkg::NDIFF];
  logic signed [PW-1:0]  prod   [spcc_pkg::NPROD];
  spcc_pkg::spcc_flags_t flags1, flags2;
  logic signed [CW-1:0]  den, tn, un;
  spcc_pkg::spcc_stat_t  stat;

  // a stage advances when it is empty or the next one advances
  assign en4 = !v4 || out_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign in_tready  = en1;
  assign out_tvalid = v4;
  assign out_tdata  = {{(spcc_pkg::OUT_TDATA_W - 1){1'b0}}, clear};

  spcc_diff #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk     (clk),
    .rst_n   (rst_n),
    .en_i    (en1),
    .valid_i (in_tvalid),
    .data_i  (in_tdata[8*COORD_BITS-1:0]),
    .valid_o (v1),
    .diff_o  (diff),
    .flags_o (flags1)
  );

  spcc_mul #(.COORD_BITS(COORD_BITS)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .en_i    (en2),
    .valid_i (v1),
    .diff_i  (diff),
    .flags_i (flags1),
    .valid_o (v2),
    .prod_o  (prod),
    .flags_o (flags2)
  );

  spcc_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .en_i    (en3),
    .valid_i (v2),
    .prod_i  (prod),
    .flags_i (flags2),
    .valid_o (v3),
    .den_o   (den),
    .tn_o    (tn),
    .un_o    (un),
    .stat_o  (stat)
  );

  spcc_decide #(.COORD_BITS(COORD_BITS)) u_decide (
    .clk     (clk),
    .rst_n   (rst_n),
    .en_i    (en4),
    .valid_i (v3),
    .den_i   (den),
    .tn_i    (tn),
    .un_i    (un),
    .stat_i  (stat),
    .valid_o (v4),
    .clear_o (clear)
  );

endmodule

// ===== rtl/core/spcc_checker.sv =====
// ---------------------------------------------------------------------------
// spcc_checker
// Port-level checks on the segment pair conflict checker, bound to the top.
// ---------------------------------------------------------------------------
`include "segment_pair_conflict_check_assert.svh"

module spcc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready
);

  // accepted beat followed by the output side staying open
  sequence s_free_run;
    in_tvalid && in_tready ##1 out_tready [*3];
  endsequence

  // a pending output beat is not withdrawn
  `SPCC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "output beat dropped")

  // reset empties the pipe
  `SPCC_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "output valid after reset")

  // an open output side never throttles the input
  `SPCC_ASSERT(a_ready_through, out_tready |-> in_tready, "input stalled with output ready")

  // an accepted beat reaches the output once s_free_run has completed
  `SPCC_ASSERT(a_latency, s_free_run |=> out_tvalid, "result missing after pipeline latency")

endmodule

bind segment_pair_conflict_check spcc_checker u_spcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: segment pair conflict checker testbench
// A stream of segment pairs goes in: first a set of hand-picked geometric
// cases, then random pairs, mostly built so they land in each branch of the
// test. Both stream sides stall in random bursts. Each result beat is checked
// against an exact integer model of the crossing/overlap decision.
// ----------------------------------------------------------------------------
module tb;

  localparam int CB    = spcc_pkg::COORD_BITS_DEF;
  localparam int IN_W  = ((8 * CB + 7) / 8) * 8;
  localparam int OUT_W = spcc_pkg::OUT_TDATA_W;
  localparam int RANDOM_PAIRS = 1300;

  // first field sits in the lowest bits, so it is listed last here
  typedef struct packed {
    logic signed [CB-1:0] second_end_y;
    logic signed [CB-1:0] second_end_x;
    logic signed [CB-1:0] second_start_y;
    logic signed [CB-1:0] second_start_x;
    logic signed [CB-1:0] first_end_y;
    logic signed [CB-1:0] first_end_x;
    logic signed [CB-1:0] first_start_y;
    logic signed [CB-1:0] first_start_x;
  } seg_pair_t;

  typedef enum int {
    PK_WIDE, PK_NARROW, PK_COLLINEAR, PK_TOUCH,
    PK_ADJACENT, PK_POINT, PK_PARALLEL, PK_EXTREME
  } pair_kind_t;

  class clear_board_t;
    bit          pending_clear[$];
    int unsigned failures;
    int unsigned pairs_seen;
    int unsigned clear_seen;

    function bit extents_apart(longint a0, longint a1, longint b0, longint b1);
      longint alo, ahi, blo, bhi;
      alo = (a0 < a1) ? a0 : a1;
      ahi = (a0 < a1) ? a1 : a0;
      blo = (b0 < b1) ? b0 : b1;
      bhi = (b0 < b1) ? b1 : b0;
      return (ahi < blo) || (bhi < alo);
    endfunction

    function bit clear_for(seg_pair_t p);
      longint x1, y1, x2, y2, x3, y3, x4, y4;
      longint rx, ry, sx, sy, qx, qy, den, tn, un;
      bit     on_line;
      x1 = longint'(p.first_start_x);  y1 = longint'(p.first_start_y);
      x2 = longint'(p.first_end_x);    y2 = longint'(p.first_end_y);
      x3 = longint'(p.second_start_x); y3 = longint'(p.second_start_y);
      x4 = longint'(p.second_end_x);   y4 = longint'(p.second_end_y);
      rx = x2 - x1; ry = y2 - y1;
      sx = x4 - x3; sy = y4 - y3;
      qx = x3 - x1; qy = y3 - y1;
      den = rx * sy - ry * sx;
      if (den == 0) begin
        on_line = (rx * qy - ry * qx == 0) &&
                  (rx * (y4 - y1) - ry * (x4 - x1) == 0) &&
                  (sx * (y1 - y3) - sy * (x1 - x3) == 0) &&
                  (sx * (y2 - y3) - sy * (x2 - x3) == 0);
        if (on_line)
          return extents_apart(x1, x2, x3, x4) || extents_apart(y1, y2, y3, y4);
        return 1'b1;
      end
      if (x2 == x3 && y2 == y3)
        return 1'b1;
      tn = qx * sy - qy * sx;
      un = qx * ry - qy * rx;
      if (den < 0) begin
        den = -den;
        tn  = -tn;
        un  = -un;
      end
      return !(tn >= 0 && tn <= den && un >= 0 && un <= den);
    endfunction

    function void note_pair(seg_pair_t p);
      pending_clear = {pending_clear, clear_for(p)};
    endfunction

    function void check_result(logic [OUT_W-1:0] beat);
      bit want;
      if (pending_clear.size() == 0) begin
        failures++;
        $display("%0t: segments_clear unexpected beat: expected none, actual %b",
                 $time, beat[0]);
        return;
      end
      want = pending_clear.pop_front();
      pairs_seen++;
      if (want)
        clear_seen++;
      if (beat[0] !== want) begin
        failures++;
        $display("%0t: segments_clear mismatch: expected %b, actual %b",
                 $time, want, beat[0]);
      end
    endfunction

    function int pending();
      return pending_clear.size();
    endfunction

    function void close();
      if (pending_clear.size() != 0) begin
        failures += pending_clear.size();
        $display("%0t: segments_clear missing: expected %0d more beats, actual 0",
                 $time, pending_clear.size());
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;

  bit                quiet_tail;
  clear_board_t      board = new();

  segment_pair_conflict_check DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        board.note_pair(seg_pair_t'(in_tdata));
      if (out_tvalid && out_tready)
        board.check_result(out_tdata);
    end
  end

  // result side back-pressure
  initial begin
    int n;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 18);
        out_tready <= 1'b0;
      end else begin
        n = $urandom_range(1, 24);
        out_tready <= 1'b1;
      end
      repeat (n) @(posedge clk);
    end
  end

  function automatic seg_pair_t mk(int x1, int y1, int x2, int y2,
                                   int x3, int y3, int x4, int y4);
    seg_pair_t p;
    p.first_start_x  = x1[CB-1:0];
    p.first_start_y  = y1[CB-1:0];
    p.first_end_x    = x2[CB-1:0];
    p.first_end_y    = y2[CB-1:0];
    p.second_start_x = x3[CB-1:0];
    p.second_start_y = y3[CB-1:0];
    p.second_end_x   = x4[CB-1:0];
    p.second_end_y   = y4[CB-1:0];
    return p;
  endfunction

  function automatic int wide_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int narrow_coord();
    return int'($urandom_range(0, 16)) - 8;
  endfunction

  function automatic int extreme_coord();
    int picks[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    return picks[$urandom_range(0, 6)];
  endfunction

  function automatic seg_pair_t collinear_pair(int ox, int oy, int dx, int dy);
    int k1, k2, k3, k4;
    k1 = narrow_coord();
    k2 = narrow_coord();
    k3 = narrow_coord();
    k4 = narrow_coord();
    return mk(ox + k1 * dx, oy + k1 * dy, ox + k2 * dx, oy + k2 * dy,
              ox + k3 * dx, oy + k3 * dy, ox + k4 * dx, oy + k4 * dy);
  endfunction

  function automatic seg_pair_t make_pair(pair_kind_t kind);
    int x1, y1, x2, y2, x3, y3, x4, y4, dx, dy, ox, oy, pick;
    pick = $urandom_range(0, 3);
    unique case (kind)
      PK_WIDE: begin
        return mk(wide_coord(), wide_coord(), wide_coord(), wide_coord(),
                  wide_coord(), wide_coord(), wide_coord(), wide_coord());
      end
      PK_NARROW: begin
        return mk(narrow_coord(), narrow_coord(), narrow_coord(), narrow_coord(),
                  narrow_coord(), narrow_coord(), narrow_coord(), narrow_coord());
      end
      PK_COLLINEAR: begin
        // four points on one line through a random base
        ox = int'($urandom_range(0, 32000)) - 16000;
        oy = int'($urandom_range(0, 32000)) - 16000;
        dx = (pick == 0) ? 0 : int'($urandom_range(0, 200)) - 100;
        dy = (pick == 1) ? 0 : int'($urandom_range(0, 200)) - 100;
        return collinear_pair(ox, oy, dx, dy);
      end
      PK_TOUCH: begin
        // second segment starts or ends at the midpoint of the first
        x1 = int'($urandom_range(0, 32000)) - 16000;
        y1 = int'($urandom_range(0, 32000)) - 16000;
        dx = int'($urandom_range(0, 2000)) - 1000;
        dy = int'($urandom_range(0, 2000)) - 1000;
        x3 = x1 + dx;
        y3 = y1 + dy;
        x4 = x3 + narrow_coord() * 100;
        y4 = y3 + narrow_coord() * 100;
        if (pick[0])
          return mk(x1, y1, x1 + 2 * dx, y1 + 2 * dy, x3, y3, x4, y4);
        return mk(x1, y1, x1 + 2 * dx, y1 + 2 * dy, x4, y4, x3, y3);
      end
      PK_ADJACENT: begin
        if (pick[0]) begin
          x2 = wide_coord(); y2 = wide_coord();
          return mk(wide_coord(), wide_coord(), x2, y2, x2, y2, wide_coord(), wide_coord());
        end
        x2 = narrow_coord(); y2 = narrow_coord();
        return mk(narrow_coord(), narrow_coord(), x2, y2, x2, y2,
                  narrow_coord(), narrow_coord());
      end
      PK_POINT: begin
        x1 = narrow_coord(); y1 = narrow_coord();
        x2 = narrow_coord(); y2 = narrow_coord();
        x3 = narrow_coord(); y3 = narrow_coord();
        x4 = narrow_coord(); y4 = narrow_coord();
        unique case (pick)
          0: return mk(x1, y1, x1, y1, x3, y3, x4, y4);
          1: return mk(x1, y1, x2, y2, x3, y3, x3, y3);
          2: return mk(x1, y1, x1, y1, x3, y3, x3, y3);
          default: return mk(x1, y1, x1, y1, x1, y1, x1, y1);
        endcase
      end
      PK_PARALLEL: begin
        x1 = int'($urandom_range(0, 20000)) - 10000;
        y1 = int'($urandom_range(0, 20000)) - 10000;
        dx = int'($urandom_range(0, 400)) - 200;
        dy = int'($urandom_range(0, 400)) - 200;
        ox = narrow_coord();
        oy = narrow_coord();
        if (pick[0])
          return mk(x1, y1, x1 + dx, y1 + dy, x1 + ox, y1 + oy, x1 + dx + ox, y1 + dy + oy);
        return mk(x1, y1, x1 + dx, y1 + dy, x1 + dx + ox, y1 + dy + oy, x1 + ox, y1 + oy);
      end
      default: begin
        return mk(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                  extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
      end
    endcase
  endfunction

  task automatic send_pair(seg_pair_t p);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold the input side until every pending result has come out or the limit runs out
  task automatic drain_results(int limit);
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (board.pending() != 0 && waited < limit);
  endtask

  initial begin
    int         sel;
    pair_kind_t kind;
    quiet_tail = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));                 // coincident points
    send_pair(mk(1, 2, 1, 2, 3, 4, 3, 4));                 // distinct points
    send_pair(mk(-10, -10, 10, 10, -10, 10, 10, -10));     // plain cross
    send_pair(mk(-10, 10, 10, -10, -10, -10, 10, 10));     // cross, den positive
    send_pair(mk(0, 0, 1, 1, 5, 0, 6, -1));                // lines meet outside
    send_pair(mk(0, 0, 10, 0, 5, 0, 15, 0));               // horizontal overlap
    send_pair(mk(0, 0, 4, 0, 5, 0, 9, 0));                 // horizontal disjoint
    send_pair(mk(3, -5, 3, 5, 3, 0, 3, 9));                // vertical overlap
    send_pair(mk(3, -5, 3, -1, 3, 0, 3, 9));               // vertical disjoint
    send_pair(mk(0, 0, 3, 3, 3, 3, 6, 6));                 // collinear, end to end
    send_pair(mk(10, 0, 0, 0, 2, 0, 8, 0));                // collinear, contained
    send_pair(mk(0, 0, 10, 0, 0, 1, 10, 1));               // parallel, apart
    send_pair(mk(0, 0, 5, 5, 5, 5, 10, 0));                // adjacent
    send_pair(mk(0, 0, 10, 0, 5, 0, 5, 7));                // T junction
    send_pair(mk(0, 0, 4, 4, 0, 0, 4, -4));                // shared start point
    send_pair(mk(0, 0, 10, 10, 4, 4, 4, 4));               // point on segment
    send_pair(mk(0, 0, 10, 10, 4, 5, 4, 5));               // point off line
    send_pair(mk(0, 0, 4, 0, 4, -2, 4, 2));                // touch at far end
    send_pair(mk(0, 0, 4, 0, 5, -2, 5, 2));                // near miss
    send_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(mk(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
    send_pair(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(mk(-32768, 32767, 32767, -32768, 32767, -32768, -32768, 32767));
    drain_results(5000);

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i == RANDOM_PAIRS / 2)
        drain_results(5000);
      if (i == RANDOM_PAIRS - 200)
        quiet_tail = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 20)      kind = PK_WIDE;
      else if (sel < 36) kind = PK_NARROW;
      else if (sel < 52) kind = PK_COLLINEAR;
      else if (sel < 62) kind = PK_TOUCH;
      else if (sel < 70) kind = PK_ADJACENT;
      else if (sel < 79) kind = PK_POINT;
      else if (sel < 89) kind = PK_PARALLEL;
      else               kind = PK_EXTREME;
      send_pair(make_pair(kind));
    end

    drain_results(5000);
    repeat (8) @(posedge clk);
    board.close();
    $display("covered %0d segment pairs: %0d clear, %0d in conflict",
             board.pairs_seen, board.clear_seen, board.pairs_seen - board.clear_seen);
    if (board.failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== segment_pair_conflict_check.f =====
+incdir+rtl/core
rtl/core/spcc_pkg.sv
rtl/core/spcc_diff.sv
rtl/core/spcc_mul.sv
rtl/core/spcc_cross.sv
rtl/core/spcc_decide.sv
rtl/core/segment_pair_conflict_check.sv
rtl/core/spcc_checker.sv
verif/tb.sv
